[rtl/core/three_level_task_scheduler_top_defines.svh]
// Assertion macros for the three-level task scheduler.
`ifndef THREE_LEVEL_TASK_SCHEDULER_TOP_DEFINES_SVH
`define THREE_LEVEL_TASK_SCHEDULER_TOP_DEFINES_SVH

// Checks that a consequence holds in the same cycle as its antecedent.
`define TLTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlts: same-cycle check failed");

// Checks that a consequence holds in the cycle after its antecedent.
`define TLTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlts: next-cycle check failed");

`endif

[rtl/core/tlts_pkg.sv]
// Shared constants for the three-level task scheduler.
package tlts_pkg;

    // Fixed field widths of the command, result and configuration ports and of the slot timer.
    localparam int OP_W      = 4;
    localparam int SLOT_W    = 6;
    localparam int IN_CHAN_W = 32;
    localparam int TMR_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CREATE = 4'd0;
    localparam logic [OP_W-1:0] OP_PICK   = 4'd1;
    localparam logic [OP_W-1:0] OP_YIELD  = 4'd2;
    localparam logic [OP_W-1:0] OP_SLEEP  = 4'd3;
    localparam logic [OP_W-1:0] OP_WAKEUP = 4'd4;
    localparam logic [OP_W-1:0] OP_KILL   = 4'd5;
    localparam logic [OP_W-1:0] OP_EXIT   = 4'd6;
    localparam logic [OP_W-1:0] OP_REAP   = 4'd7;
    localparam logic [OP_W-1:0] OP_TICK   = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WOKEN_QUANTUM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_QUANTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CHANNEL   = 2'd2;

    // Quantum values after reset.
    localparam logic [TMR_W-1:0] WOKEN_QUANTUM_RESET  = 4'd5;
    localparam logic [TMR_W-1:0] NORMAL_QUANTUM_RESET = 4'd10;

endpackage

[rtl/core/three_level_task_scheduler_top.sv]
// Top level of the three-level task scheduler: list sequencer and slot memories.
//
// A command item is taken when start is high and busy is low; its single result
// appears on status, chosen_slot and chosen_killed for one cycle with done high,
// and the receiver cannot stall it. After reset the block sweeps the slot memory
// with busy high before it takes the first item; configuration writes are taken
// at any time (cfg_ready is always high) and must only be issued while the block
// is idle. All slot state sits in a one-port slot memory and a one-port channel
// memory, so the time an item takes depends on the list walks: create, yield,
// sleep, reap and kill make at most one unlink-and-append move; pick, tick and
// wakeup walk their lists slot by slot; exit is one move plus two wakeup walks
// of the sleep list.
module three_level_task_scheduler_top #(
    parameter int NUM_SLOTS    = 64,
    parameter int NUM_LEVELS   = 3,
    parameter int CHANNEL_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [tlts_pkg::OP_W-1:0]          op,
    input  logic [tlts_pkg::SLOT_W-1:0]        task_slot,
    input  logic [tlts_pkg::IN_CHAN_W-1:0]     channel,
    output logic                               done,
    output logic                               status,
    output logic [tlts_pkg::SLOT_W-1:0]        chosen_slot,
    output logic                               chosen_killed,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlts_pkg::IN_CHAN_W-1:0]     cfg_data
);

    `include "three_level_task_scheduler_top_defines.svh"

    // Derived sizes and list codes.
    localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NUM_LISTS = NUM_LEVELS + 2;
    localparam int LW        = $clog2(NUM_LEVELS + 3);
    localparam int LIW       = $clog2(NUM_LISTS);

    localparam logic [SW:0]   NIL          = (SW + 1)'(NUM_SLOTS);
    localparam logic [LW-1:0] LIST_TIMEOUT = LW'(0);
    localparam logic [LW-1:0] LIST_WOKEN   = LW'(1);
    localparam logic [LW-1:0] LIST_NORMAL  = LW'(NUM_LEVELS - 1);
    localparam logic [LW-1:0] LIST_SLEEP   = LW'(NUM_LEVELS);
    localparam logic [LW-1:0] LIST_ZOMBIE  = LW'(NUM_LEVELS + 1);
    localparam logic [LW-1:0] LIST_FREE    = LW'(NUM_LEVELS + 2);
    localparam logic [LW-1:0] LIST_LIMIT   = LW'(NUM_LISTS);

    // One slot record of the slot memory.
    typedef struct packed {
        logic [LW-1:0]                 lst;
        logic                          run;
        logic [tlts_pkg::TMR_W-1:0]    tmr;
        logic                          kil;
        logic [SW:0]                   nxt;
        logic [SW:0]                   prv;
    } rec_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_GET,
        ST_U1, ST_U1W, ST_U2, ST_U2W, ST_A1, ST_A1W, ST_A2,
        ST_WSTART, ST_WREAD, ST_WEVAL, ST_WEND,
        ST_FINREAD, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [tlts_pkg::OP_W-1:0]   op_reg, op_next;
    logic [tlts_pkg::SLOT_W-1:0] s_reg, s_next;
    logic [CHANNEL_BITS-1:0]     chan_reg, chan_next;
    logic [CHANNEL_BITS-1:0]     wchan_reg, wchan_next;
    logic [CHANNEL_BITS-1:0]     init_reg, init_next;
    logic [tlts_pkg::TMR_W-1:0]  wq_reg, wq_next;
    logic [tlts_pkg::TMR_W-1:0]  nq_reg, nq_next;
    rec_t                        cur_reg, cur_next;
    logic [SW-1:0]               m_reg, m_next;
    logic [LW-1:0]               tgt_reg, tgt_next;
    logic [tlts_pkg::TMR_W-1:0]  ntmr_reg, ntmr_next;
    logic                        nkil_reg, nkil_next;
    logic [SW:0]                 tlink_reg, tlink_next;
    logic [SW:0]                 p_reg, p_next;
    logic [SW:0]                 guard_reg, guard_next;
    logic [LW-1:0]               lvl_reg, lvl_next;
    logic                        found_reg, found_next;
    logic                        second_reg, second_next;
    logic [SW-1:0]               clr_reg, clr_next;
    logic                        done_reg, done_next;
    logic                        res_status_reg, res_status_next;
    logic [tlts_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic                        res_kil_reg, res_kil_next;
    logic [SW:0]                 head_reg [NUM_LISTS];
    logic [SW:0]                 head_next [NUM_LISTS];
    logic [SW:0]                 tail_reg [NUM_LISTS];
    logic [SW:0]                 tail_next [NUM_LISTS];

    // Memory ports.
    logic                        rec_we;
    logic [SW-1:0]               rec_addr;
    rec_t                        rec_wdata;
    rec_t                        rec_rd;
    logic                        ch_we;
    logic [CHANNEL_BITS-1:0]     ch_rd;

    logic                        s_ok;
    logic                        in_ok;
    logic                        rd_runnable;
    logic [SW-1:0]               s_idx;
    logic [tlts_pkg::TMR_W-1:0]  tdec;
    logic                        ends_ok;

    tlts_ram #(.WIDTH($bits(rec_t)), .DEPTH(NUM_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (rec_we),
        .addr  (rec_addr),
        .wdata (rec_wdata),
        .rdata (rec_rd)
    );

    tlts_ram #(.WIDTH(CHANNEL_BITS), .DEPTH(NUM_SLOTS)) u_chan_ram (
        .clk   (clk),
        .we    (ch_we),
        .addr  (rec_addr),
        .wdata (chan_reg),
        .rdata (ch_rd)
    );

    assign s_ok        = (32'(s_reg) < 32'(NUM_SLOTS));
    assign in_ok       = (32'(task_slot) < 32'(NUM_SLOTS));
    assign s_idx       = SW'(s_reg);
    assign rd_runnable = (rec_rd.lst < LW'(NUM_LEVELS));
    assign tdec        = rec_rd.tmr - 4'd1;

    // Sequencer: next state, list ends and memory accesses.
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        op_next         = op_reg;
        s_next          = s_reg;
        chan_next       = chan_reg;
        wchan_next      = wchan_reg;
        init_next       = init_reg;
        wq_next         = wq_reg;
        nq_next         = nq_reg;
        cur_next        = cur_reg;
        m_next          = m_reg;
        tgt_next        = tgt_reg;
        ntmr_next       = ntmr_reg;
        nkil_next       = nkil_reg;
        tlink_next      = tlink_reg;
        p_next          = p_reg;
        guard_next      = guard_reg;
        lvl_next        = lvl_reg;
        found_next      = found_reg;
        second_next     = second_reg;
        clr_next        = clr_reg;
        done_next       = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_kil_next    = res_kil_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        rec_we          = 1'b0;
        rec_addr        = m_reg;
        rec_wdata       = rec_rd;
        ch_we           = 1'b0;

        // Configuration writes; indexes beyond the list are ignored.
        if (cfg_valid)
        begin
            case (cfg_index)
                tlts_pkg::CFG_WOKEN_QUANTUM:  wq_next = cfg_data[tlts_pkg::TMR_W-1:0];
                tlts_pkg::CFG_NORMAL_QUANTUM: nq_next = cfg_data[tlts_pkg::TMR_W-1:0];
                tlts_pkg::CFG_INIT_CHANNEL:   init_next = CHANNEL_BITS'(cfg_data);
                default: ;
            endcase
        end

        case (state_reg)
            // Sweep every slot to free after reset.
            ST_CLEAR:
            begin
                rec_we    = 1'b1;
                rec_addr  = clr_reg;
                rec_wdata = '{lst: LIST_FREE, run: 1'b0, tmr: '0, kil: 1'b0,
                              nxt: NIL, prv: NIL};
                if (clr_reg == SW'(NUM_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            // Take a command item.
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    s_next      = task_slot;
                    chan_next   = CHANNEL_BITS'(channel);
                    found_next  = 1'b0;
                    second_next = 1'b0;
                    case (op)
                        tlts_pkg::OP_PICK:
                        begin
                            lvl_next   = LIST_TIMEOUT;
                            state_next = ST_WSTART;
                        end
                        tlts_pkg::OP_TICK:
                        begin
                            lvl_next   = LIST_WOKEN;
                            state_next = ST_WSTART;
                        end
                        tlts_pkg::OP_WAKEUP:
                        begin
                            lvl_next   = LIST_SLEEP;
                            wchan_next = CHANNEL_BITS'(channel);
                            state_next = ST_WSTART;
                        end
                        default:
                        begin
                            if (in_ok)
                            begin
                                rec_addr   = SW'(task_slot);
                                state_next = ST_GET;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                                res_slot_next   = task_slot;
                                res_kil_next    = 1'b0;
                                state_next      = ST_OUT;
                            end
                        end
                    endcase
                end
            end

            // Named slot record is in; decide the operation.
            ST_GET:
            begin
                res_status_next = 1'b1;
                res_slot_next   = s_reg;
                res_kil_next    = rec_rd.kil;
                cur_next        = rec_rd;
                m_next          = s_idx;
                ntmr_next       = rec_rd.tmr;
                nkil_next       = rec_rd.kil;
                ret_next        = ST_OUT;
                state_next      = ST_OUT;
                case (op_reg)
                    tlts_pkg::OP_CREATE:
                    begin
                        if (rec_rd.lst == LIST_FREE)
                        begin
                            tgt_next        = LIST_NORMAL;
                            ntmr_next       = nq_reg;
                            nkil_next       = 1'b0;
                            res_kil_next    = 1'b0;
                            res_status_next = 1'b0;
                            state_next      = ST_U1;
                        end
                    end
                    tlts_pkg::OP_YIELD:
                    begin
                        if (rd_runnable)
                        begin
                            tgt_next        = LIST_NORMAL;
                            ntmr_next       = nq_reg;
                            res_status_next = 1'b0;
                            state_next      = ST_U1;
                        end
                    end
                    tlts_pkg::OP_SLEEP:
                    begin
                        if (rd_runnable)
                        begin
                            rec_addr        = s_idx;
                            ch_we           = 1'b1;
                            tgt_next        = LIST_SLEEP;
                            res_status_next = 1'b0;
                            state_next      = ST_U1;
                        end
                    end
                    tlts_pkg::OP_KILL:
                    begin
                        if (rd_runnable)
                        begin
                            rec_we          = 1'b1;
                            rec_addr        = s_idx;
                            rec_wdata.kil   = 1'b1;
                            res_kil_next    = 1'b1;
                            res_status_next = 1'b0;
                        end
                        else if (rec_rd.lst == LIST_SLEEP)
                        begin
                            tgt_next        = LIST_WOKEN;
                            ntmr_next       = wq_reg;
                            nkil_next       = 1'b1;
                            res_kil_next    = 1'b1;
                            res_status_next = 1'b0;
                            state_next      = ST_U1;
                        end
                    end
                    tlts_pkg::OP_EXIT:
                    begin
                        if (rd_runnable || rec_rd.lst == LIST_SLEEP)
                        begin
                            tgt_next        = LIST_ZOMBIE;
                            res_status_next = 1'b0;
                            lvl_next        = LIST_SLEEP;
                            wchan_next      = chan_reg;
                            second_next     = 1'b1;
                            ret_next        = ST_WSTART;
                            state_next      = ST_U1;
                        end
                    end
                    tlts_pkg::OP_REAP:
                    begin
                        if (rec_rd.lst == LIST_ZOMBIE)
                        begin
                            tgt_next        = LIST_FREE;
                            ntmr_next       = '0;
                            nkil_next       = 1'b0;
                            res_kil_next    = 1'b0;
                            res_status_next = 1'b0;
                            state_next      = ST_U1;
                        end
                    end
                    default: ;
                endcase
            end

            // Unlink: fix the predecessor or the list head.
            ST_U1:
            begin
                if (cur_reg.lst >= LIST_LIMIT)
                begin
                    state_next = ST_A1;
                end
                else if (cur_reg.prv == NIL)
                begin
                    head_next[cur_reg.lst[LIW-1:0]] = cur_reg.nxt;
                    state_next = ST_U2;
                end
                else
                begin
                    rec_addr   = cur_reg.prv[SW-1:0];
                    state_next = ST_U1W;
                end
            end

            ST_U1W:
            begin
                rec_we        = 1'b1;
                rec_addr      = cur_reg.prv[SW-1:0];
                rec_wdata.nxt = cur_reg.nxt;
                state_next    = ST_U2;
            end

            // Unlink: fix the successor or the list tail.
            ST_U2:
            begin
                if (cur_reg.nxt == NIL)
                begin
                    tail_next[cur_reg.lst[LIW-1:0]] = cur_reg.prv;
                    state_next = ST_A1;
                end
                else
                begin
                    rec_addr   = cur_reg.nxt[SW-1:0];
                    state_next = ST_U2W;
                end
            end

            ST_U2W:
            begin
                rec_we        = 1'b1;
                rec_addr      = cur_reg.nxt[SW-1:0];
                rec_wdata.prv = cur_reg.prv;
                state_next    = ST_A1;
            end

            // Append: hook the slot behind the target tail; a move to free links nothing.
            ST_A1:
            begin
                if (tgt_reg == LIST_FREE)
                begin
                    tlink_next = NIL;
                    state_next = ST_A2;
                end
                else
                begin
                    tlink_next = tail_reg[tgt_reg[LIW-1:0]];
                    tail_next[tgt_reg[LIW-1:0]] = {1'b0, m_reg};
                    if (tail_reg[tgt_reg[LIW-1:0]] == NIL)
                    begin
                        head_next[tgt_reg[LIW-1:0]] = {1'b0, m_reg};
                        state_next = ST_A2;
                    end
                    else
                    begin
                        rec_addr   = tail_reg[tgt_reg[LIW-1:0]][SW-1:0];
                        state_next = ST_A1W;
                    end
                end
            end

            ST_A1W:
            begin
                rec_we        = 1'b1;
                rec_addr      = tlink_reg[SW-1:0];
                rec_wdata.nxt = {1'b0, m_reg};
                state_next    = ST_A2;
            end

            // Write the moved slot's own record.
            ST_A2:
            begin
                rec_we     = 1'b1;
                rec_addr   = m_reg;
                rec_wdata  = '{lst: tgt_reg, run: 1'b0, tmr: ntmr_reg, kil: nkil_reg,
                               nxt: NIL, prv: tlink_reg};
                state_next = ret_reg;
            end

            // List walks for pick, tick and wakeup.
            ST_WSTART:
            begin
                p_next     = head_reg[lvl_reg[LIW-1:0]];
                guard_next = '0;
                state_next = ST_WREAD;
            end

            ST_WREAD:
            begin
                if (p_reg == NIL || guard_reg == NIL)
                begin
                    state_next = ST_WEND;
                end
                else
                begin
                    rec_addr   = p_reg[SW-1:0];
                    state_next = ST_WEVAL;
                end
            end

            ST_WEVAL:
            begin
                guard_next = guard_reg + 1'b1;
                p_next     = rec_rd.nxt;
                state_next = ST_WREAD;
                cur_next   = rec_rd;
                m_next     = p_reg[SW-1:0];
                nkil_next  = rec_rd.kil;
                ret_next   = ST_WREAD;
                rec_addr   = p_reg[SW-1:0];
                if (op_reg == tlts_pkg::OP_PICK)
                begin
                    if (!rec_rd.run)
                    begin
                        rec_we          = 1'b1;
                        rec_wdata.run   = 1'b1;
                        res_status_next = 1'b0;
                        res_slot_next   = tlts_pkg::SLOT_W'(p_reg);
                        res_kil_next    = rec_rd.kil;
                        state_next      = ST_OUT;
                    end
                end
                else if (op_reg == tlts_pkg::OP_TICK)
                begin
                    if (!rec_rd.run)
                    begin
                        if (tdec == '0)
                        begin
                            tgt_next   = LIST_TIMEOUT;
                            ntmr_next  = '0;
                            state_next = ST_U1;
                        end
                        else
                        begin
                            rec_we        = 1'b1;
                            rec_wdata.tmr = tdec;
                        end
                    end
                end
                else if (ch_rd == wchan_reg)
                begin
                    found_next = 1'b1;
                    tgt_next   = LIST_WOKEN;
                    ntmr_next  = wq_reg;
                    state_next = ST_U1;
                end
            end

            // End of one list walk.
            ST_WEND:
            begin
                case (op_reg)
                    tlts_pkg::OP_PICK:
                    begin
                        if (lvl_reg == LIST_NORMAL)
                        begin
                            res_status_next = 1'b1;
                            res_slot_next   = '0;
                            res_kil_next    = 1'b0;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            lvl_next   = lvl_reg + 1'b1;
                            state_next = ST_WSTART;
                        end
                    end
                    tlts_pkg::OP_TICK:
                    begin
                        res_status_next = 1'b0;
                        if (lvl_reg == LIST_NORMAL)
                        begin
                            state_next = ST_FINREAD;
                        end
                        else
                        begin
                            lvl_next   = lvl_reg + 1'b1;
                            state_next = ST_WSTART;
                        end
                    end
                    tlts_pkg::OP_EXIT:
                    begin
                        if (second_reg)
                        begin
                            second_next = 1'b0;
                            wchan_next  = init_reg;
                            state_next  = ST_WSTART;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    default:
                    begin
                        res_status_next = !found_reg;
                        state_next      = ST_FINREAD;
                    end
                endcase
            end

            // Fetch the killed flag of the named slot.
            ST_FINREAD:
            begin
                res_slot_next = s_reg;
                if (s_ok)
                begin
                    rec_addr   = s_idx;
                    state_next = ST_FIN;
                end
                else
                begin
                    res_kil_next = 1'b0;
                    state_next   = ST_OUT;
                end
            end

            ST_FIN:
            begin
                res_kil_next = rec_rd.kil;
                state_next   = ST_OUT;
            end

            ST_OUT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, list ends and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            ret_reg        <= ST_OUT;
            clr_reg        <= '0;
            done_reg       <= 1'b0;
            wq_reg         <= tlts_pkg::WOKEN_QUANTUM_RESET;
            nq_reg         <= tlts_pkg::NORMAL_QUANTUM_RESET;
            init_reg       <= '0;
            found_reg      <= 1'b0;
            second_reg     <= 1'b0;
            guard_reg      <= '0;
            lvl_reg        <= '0;
            res_status_reg <= 1'b0;
            res_slot_reg   <= '0;
            res_kil_reg    <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            clr_reg        <= clr_next;
            done_reg       <= done_next;
            wq_reg         <= wq_next;
            nq_reg         <= nq_next;
            init_reg       <= init_next;
            found_reg      <= found_next;
            second_reg     <= second_next;
            guard_reg      <= guard_next;
            lvl_reg        <= lvl_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_kil_reg    <= res_kil_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
        end
    end

    // Item payload and working registers.
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        s_reg     <= s_next;
        chan_reg  <= chan_next;
        wchan_reg <= wchan_next;
        cur_reg   <= cur_next;
        m_reg     <= m_next;
        tgt_reg   <= tgt_next;
        ntmr_reg  <= ntmr_next;
        nkil_reg  <= nkil_next;
        tlink_reg <= tlink_next;
        p_reg     <= p_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign status        = res_status_reg;
    assign chosen_slot   = res_slot_reg;
    assign chosen_killed = res_kil_reg;

    // An empty list has both ends empty.
    always_comb
    begin
        ends_ok = 1'b1;
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            ends_ok = ends_ok && ((head_reg[i] == NIL) == (tail_reg[i] == NIL));
        end
    end

    `TLTS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `TLTS_ASSERT_NEXT(a_out_state_strobes, state_reg == ST_OUT, done && !busy)
    `TLTS_ASSERT_NOW(a_done_after_out, done, $past(state_reg == ST_OUT))
    `TLTS_ASSERT_NOW(a_idle_ends_consistent, state_reg == ST_IDLE, ends_ok)

endmodule

[rtl/core/tlts_ram.sv]
// Single-port synchronous RAM with registered read data.
module tlts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: write, and read the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[bench/tb_three_level_task_scheduler_top.sv]
// Self-checking testbench for the three-level task scheduler with a built-in list predictor.
`timescale 1ns / 1ps

module tb_three_level_task_scheduler_top;

    localparam int SLOTS      = 64;
    localparam int NIL        = SLOTS;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 300;

    // List numbers of the predictor.
    localparam int LST_TIMEOUT = 0;
    localparam int LST_WOKEN   = 1;
    localparam int LST_NORMAL  = 2;
    localparam int LST_SLEEP   = 3;
    localparam int LST_ZOMBIE  = 4;
    localparam int LST_FREE    = 5;

    typedef struct packed {
        logic [tlts_pkg::OP_W-1:0]      op;
        logic [tlts_pkg::SLOT_W-1:0]    slot;
        logic [tlts_pkg::IN_CHAN_W-1:0] chan;
    } sched_cmd_t;

    typedef struct packed {
        logic                        status;
        logic [tlts_pkg::SLOT_W-1:0] slot;
        logic                        killed;
    } sched_rsp_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [tlts_pkg::OP_W-1:0]      op;
    logic [tlts_pkg::SLOT_W-1:0]    task_slot;
    logic [tlts_pkg::IN_CHAN_W-1:0] channel;
    logic                           done;
    logic                           status;
    logic [tlts_pkg::SLOT_W-1:0]    chosen_slot;
    logic                           chosen_killed;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tlts_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tlts_pkg::IN_CHAN_W-1:0] cfg_data;

    three_level_task_scheduler_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .task_slot     (task_slot),
        .channel       (channel),
        .done          (done),
        .status        (status),
        .chosen_slot   (chosen_slot),
        .chosen_killed (chosen_killed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Scheduler state as the predictor sees it.
    logic [3:0]                     woken_q;
    logic [3:0]                     normal_q;
    logic [tlts_pkg::IN_CHAN_W-1:0] init_chan;
    int                             slot_lst   [SLOTS];
    bit                             on_cpu     [SLOTS];
    logic [3:0]                     quantum    [SLOTS];
    logic [tlts_pkg::IN_CHAN_W-1:0] wait_chan  [SLOTS];
    bit                             killed     [SLOTS];
    int                             nxt        [SLOTS];
    int                             prv        [SLOTS];
    int                             lst_head   [6];
    int                             lst_tail   [6];

    sched_cmd_t pending_cmds[$];
    sched_rsp_t expected_rsps[$];
    int         mismatches;
    int         idle_cycles;
    int         gap_left;
    bit         no_gaps;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void sched_clear();
        woken_q   = tlts_pkg::WOKEN_QUANTUM_RESET;
        normal_q  = tlts_pkg::NORMAL_QUANTUM_RESET;
        init_chan = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_lst[i] = LST_FREE;
            on_cpu[i]   = 0;
            quantum[i]  = '0;
            wait_chan[i] = '0;
            killed[i]   = 0;
            nxt[i]      = NIL;
            prv[i]      = NIL;
        end
        for (int l = 0; l < 6; l++)
        begin
            lst_head[l] = NIL;
            lst_tail[l] = NIL;
        end
    endfunction

    function automatic void detach(int s);
        int l;
        int p;
        int n;
        l = slot_lst[s];
        p = prv[s];
        n = nxt[s];
        if (l >= LST_FREE)
            return;
        if (p == NIL) lst_head[l] = n; else nxt[p] = n;
        if (n == NIL) lst_tail[l] = p; else prv[n] = p;
        nxt[s] = NIL;
        prv[s] = NIL;
        slot_lst[s] = LST_FREE;
    endfunction

    function automatic void enqueue_tail(int l, int s);
        int t;
        t = lst_tail[l];
        prv[s] = t;
        nxt[s] = NIL;
        if (t == NIL) lst_head[l] = s; else nxt[t] = s;
        lst_tail[l] = s;
        slot_lst[s] = l;
        on_cpu[s] = 0;
    endfunction

    function automatic void make_woken(int s);
        detach(s);
        quantum[s] = woken_q;
        enqueue_tail(LST_WOKEN, s);
    endfunction

    function automatic int wake_sleepers(logic [tlts_pkg::IN_CHAN_W-1:0] ch);
        int cnt;
        int p;
        int n;
        cnt = 0;
        p = lst_head[LST_SLEEP];
        for (int g = 0; g < SLOTS && p != NIL; g++)
        begin
            n = nxt[p];
            if (wait_chan[p] == ch)
            begin
                make_woken(p);
                cnt++;
            end
            p = n;
        end
        return cnt;
    endfunction

    // Timers of waiting tasks at the woken and normal levels count down.
    function automatic void tick_timers();
        int p;
        int n;
        for (int l = LST_WOKEN; l <= LST_NORMAL; l++)
        begin
            p = lst_head[l];
            for (int g = 0; g < SLOTS && p != NIL; g++)
            begin
                n = nxt[p];
                if (!on_cpu[p])
                begin
                    quantum[p] = quantum[p] - 4'd1;
                    if (quantum[p] == 4'd0)
                    begin
                        detach(p);
                        enqueue_tail(LST_TIMEOUT, p);
                    end
                end
                p = n;
            end
        end
    endfunction

    // Applies one command to the predictor and returns the result it expects.
    function automatic sched_rsp_t sched_predict(sched_cmd_t c);
        sched_rsp_t r;
        int s;
        int l;
        int p;
        bit runnable;
        s = int'(c.slot);
        l = slot_lst[s];
        runnable = l <= LST_NORMAL;
        r.status = 1'b1;
        r.slot = c.slot;
        if (c.op == tlts_pkg::OP_PICK)
        begin
            r.slot = '0;
            r.killed = 1'b0;
            for (int lv = 0; lv <= LST_NORMAL; lv++)
            begin
                p = lst_head[lv];
                for (int g = 0; g < SLOTS && p != NIL; g++)
                begin
                    if (!on_cpu[p])
                    begin
                        on_cpu[p] = 1;
                        r.status = 1'b0;
                        r.slot = tlts_pkg::SLOT_W'(p);
                        r.killed = killed[p];
                        return r;
                    end
                    p = nxt[p];
                end
            end
            return r;
        end
        case (c.op)
            tlts_pkg::OP_CREATE:
                if (l == LST_FREE)
                begin
                    quantum[s] = normal_q;
                    killed[s] = 0;
                    enqueue_tail(LST_NORMAL, s);
                    r.status = 1'b0;
                end
            tlts_pkg::OP_YIELD:
                if (runnable)
                begin
                    detach(s);
                    quantum[s] = normal_q;
                    enqueue_tail(LST_NORMAL, s);
                    r.status = 1'b0;
                end
            tlts_pkg::OP_SLEEP:
                if (runnable)
                begin
                    detach(s);
                    wait_chan[s] = c.chan;
                    enqueue_tail(LST_SLEEP, s);
                    r.status = 1'b0;
                end
            tlts_pkg::OP_WAKEUP:
                r.status = (wake_sleepers(c.chan) == 0);
            tlts_pkg::OP_KILL:
                if (runnable)
                begin
                    killed[s] = 1;
                    r.status = 1'b0;
                end
                else if (l == LST_SLEEP)
                begin
                    killed[s] = 1;
                    make_woken(s);
                    r.status = 1'b0;
                end
            tlts_pkg::OP_EXIT:
                if (runnable || l == LST_SLEEP)
                begin
                    detach(s);
                    enqueue_tail(LST_ZOMBIE, s);
                    void'(wake_sleepers(c.chan));
                    void'(wake_sleepers(init_chan));
                    r.status = 1'b0;
                end
            tlts_pkg::OP_REAP:
                if (l == LST_ZOMBIE)
                begin
                    detach(s);
                    on_cpu[s] = 0;
                    quantum[s] = '0;
                    killed[s] = 0;
                    r.status = 1'b0;
                end
            tlts_pkg::OP_TICK:
            begin
                tick_timers();
                r.status = 1'b0;
            end
            default: ;
        endcase
        r.killed = killed[s];
        return r;
    endfunction

    // Command driver with random gaps between items unless no_gaps is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            op        <= '0;
            task_slot <= '0;
            channel   <= '0;
            gap_left  <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_rsps.push_back(sched_predict({op, task_slot, channel}));
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    sched_cmd_t c;
                    c = pending_cmds.pop_front();
                    op        <= c.op;
                    task_slot <= c.slot;
                    channel   <= c.chan;
                    start     <= 1'b1;
                    gap_left  <= no_gaps ? 0 : $urandom_range(0, 18);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d slot %0d killed %0d",
                             status, chosen_slot, chosen_killed);
            end
            else
            begin
                sched_rsp_t e;
                e = expected_rsps.pop_front();
                if (status !== e.status || chosen_slot !== e.slot
                    || chosen_killed !== e.killed)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 e.status, e.slot, e.killed,
                                 status, chosen_slot, chosen_killed);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item and no result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("three_level_task_scheduler_top regression: fail");
            $finish;
        end
    end

    task automatic add_cmd(logic [tlts_pkg::OP_W-1:0] o, int s,
                           logic [tlts_pkg::IN_CHAN_W-1:0] ch);
        sched_cmd_t c;
        c.op = o;
        c.slot = tlts_pkg::SLOT_W'(s);
        c.chan = ch;
        pending_cmds.push_back(c);
    endtask

    // Random command: mostly a few slots and channels so that tasks meet.
    task automatic add_random_cmd();
        int pick;
        int s;
        logic [tlts_pkg::IN_CHAN_W-1:0] ch;
        logic [tlts_pkg::OP_W-1:0] o;
        pick = $urandom_range(0, 99);
        if (pick < 18)      o = tlts_pkg::OP_CREATE;
        else if (pick < 34) o = tlts_pkg::OP_PICK;
        else if (pick < 43) o = tlts_pkg::OP_YIELD;
        else if (pick < 54) o = tlts_pkg::OP_SLEEP;
        else if (pick < 63) o = tlts_pkg::OP_WAKEUP;
        else if (pick < 69) o = tlts_pkg::OP_KILL;
        else if (pick < 76) o = tlts_pkg::OP_EXIT;
        else if (pick < 84) o = tlts_pkg::OP_REAP;
        else if (pick < 97) o = tlts_pkg::OP_TICK;
        else                o = tlts_pkg::OP_W'($urandom_range(9, 15));
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SLOTS - 1)
                                        : $urandom_range(0, 11);
        case ($urandom_range(0, 5))
            0:       ch = $urandom;
            1:       ch = init_chan;
            default: ch = $urandom_range(0, 3);
        endcase
        add_cmd(o, s, ch);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [tlts_pkg::CFG_IDX_W-1:0] idx,
                             logic [tlts_pkg::IN_CHAN_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            tlts_pkg::CFG_WOKEN_QUANTUM:  woken_q = val[3:0];
            tlts_pkg::CFG_NORMAL_QUANTUM: normal_q = val[3:0];
            tlts_pkg::CFG_INIT_CHANNEL:   init_chan = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: a directed pass, then random phases under several settings.
    initial
    begin
        logic [3:0] wq;
        logic [3:0] nq;
        logic [tlts_pkg::IN_CHAN_W-1:0] ic;
        mismatches = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sched_clear();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Pick on empty lists, extreme slots, every operation and unknown codes.
        add_cmd(tlts_pkg::OP_PICK, 0, '0);
        add_cmd(tlts_pkg::OP_CREATE, 0, '0);
        add_cmd(tlts_pkg::OP_CREATE, 63, '0);
        add_cmd(tlts_pkg::OP_CREATE, 0, '0);
        add_cmd(tlts_pkg::OP_PICK, 0, '0);
        add_cmd(tlts_pkg::OP_PICK, 0, '0);
        add_cmd(tlts_pkg::OP_PICK, 0, '0);
        add_cmd(tlts_pkg::OP_YIELD, 0, '0);
        add_cmd(tlts_pkg::OP_SLEEP, 63, 32'hFFFF_FFFF);
        add_cmd(tlts_pkg::OP_WAKEUP, 0, 32'h0000_0005);
        add_cmd(tlts_pkg::OP_WAKEUP, 42, 32'hFFFF_FFFF);
        add_cmd(tlts_pkg::OP_KILL, 63, '0);
        add_cmd(tlts_pkg::OP_SLEEP, 0, 32'h0000_0007);
        add_cmd(tlts_pkg::OP_KILL, 0, '0);
        add_cmd(tlts_pkg::OP_PICK, 0, '0);
        add_cmd(tlts_pkg::OP_EXIT, 63, '0);
        add_cmd(tlts_pkg::OP_KILL, 63, '0);
        add_cmd(tlts_pkg::OP_REAP, 63, '0);
        add_cmd(tlts_pkg::OP_REAP, 63, '0);
        for (int i = 0; i < 6; i++)
            add_cmd(tlts_pkg::OP_TICK, 21, 32'hA5A5_5A5A);
        add_cmd(4'd9, 1, '0);
        add_cmd(4'd15, 62, '0);
        wait_drained();

        // Random phases; each starts from an idle block with fresh settings.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin wq = 4'd1;  nq = 4'd1;  ic = '0; end
                1: begin wq = 4'd15; nq = 4'd15; ic = 32'hFFFF_FFFF; end
                2: begin wq = 4'd3;  nq = 4'd7;  ic = 32'd2; end
                3: begin wq = 4'($urandom_range(1, 15)); nq = 4'($urandom_range(1, 15));
                         ic = $urandom; end
                default: begin wq = 4'd2; nq = 4'd4; ic = 32'd1; end
            endcase
            repeat (8) @(posedge clk);
            write_reg(tlts_pkg::CFG_WOKEN_QUANTUM, tlts_pkg::IN_CHAN_W'(wq));
            write_reg(tlts_pkg::CFG_NORMAL_QUANTUM, tlts_pkg::IN_CHAN_W'(nq));
            write_reg(tlts_pkg::CFG_INIT_CHANNEL, ic);
            no_gaps = (ph == 2);
            for (int i = 0; i < 80; i++)
                add_random_cmd();
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("three_level_task_scheduler_top regression: pass");
        else
            $display("three_level_task_scheduler_top regression: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/tlts_pkg.sv
rtl/core/tlts_ram.sv
rtl/core/three_level_task_scheduler_top.sv
bench/tb_three_level_task_scheduler_top.sv
